@@ rtl/request_coalescing_tracker_core_defines.svh @@
// ----------------------------------------------------------------------------
// Request coalescing tracker assertion macros
// Shared assertion forms for the request coalescing tracker RTL.
// ----------------------------------------------------------------------------
`ifndef REQUEST_COALESCING_TRACKER_CORE_DEFINES_SVH
`define REQUEST_COALESCING_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RCT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/rct_pkg.sv @@
// ----------------------------------------------------------------------------
// Request coalescing tracker package
// Entry layout, item codes, controller states and a saturating increment.
// ----------------------------------------------------------------------------
`default_nettype none

package rct_pkg;

   localparam int unsigned CNT_W     = 16;
   localparam int unsigned STAT_W    = 32;
   localparam int unsigned CYCLE_W   = 32;
   localparam int unsigned WINDOW_W  = 16;
   localparam int unsigned KEY_W     = 10;

   localparam logic [CNT_W-1:0]    CNT_MAX      = 16'hFFFF;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd300;

   // Item kind.
   localparam logic KIND_ARRIVAL = 1'b0;
   localparam logic KIND_QUERY   = 1'b1;

   // Packet kind.
   localparam logic [1:0] PKT_REQUEST  = 2'd0;
   localparam logic [1:0] PKT_RESPONSE = 2'd1;

   // Flit kind.
   localparam logic [1:0] FLIT_HEAD      = 2'd0;
   localparam logic [1:0] FLIT_TAIL      = 2'd2;
   localparam logic [1:0] FLIT_HEAD_TAIL = 2'd3;

   typedef struct packed {
      logic [CNT_W-1:0]   global_seen;
      logic [CYCLE_W-1:0] window_start;
      logic [CNT_W-1:0]   window_seen;
      logic [CNT_W-1:0]   batch_outstanding;
      logic [CNT_W-1:0]   old_pending;
   } entry_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 16'd1;
   endfunction

endpackage

`default_nettype wire

@@ rtl/request_coalescing_tracker_core.sv @@
// ----------------------------------------------------------------------------
// Request coalescing tracker core
// Per-key duplicate tracking of request head flits, with coalesce queries.
// ----------------------------------------------------------------------------
// After reset the block sweeps its entry memory clear, one entry per cycle;
// req_ready stays low during the sweep while csr writes are taken as usual.
// After that each accepted item starts a read of the key's entry from the
// synchronous entry memory, and the lookup state then writes the modified
// entry back and loads the result register. One item is in flight at a
// time, so reads never see a stale entry. A result that waits on rsp_ready
// holds the update, which is the only stall in the lookup state.
`default_nettype none

`include "request_coalescing_tracker_core_defines.svh"

module request_coalescing_tracker_core #(
   parameter int unsigned NUM_KEYS = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_kind,
   input  wire logic [1:0]  req_packet_kind,
   input  wire logic [1:0]  req_flit_kind,
   input  wire logic [9:0]  req_feature_key,
   input  wire logic        req_already_marked,
   input  wire logic [31:0] req_now_cycle,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_coalesce_mark,
   output logic             rsp_global_dup,
   output logic             rsp_window_dup,
   output logic             rsp_inflight_dup,
   output logic [31:0]      rsp_heads_total,
   output logic [31:0]      rsp_global_coalesced,
   output logic [31:0]      rsp_window_coalesced,
   output logic [31:0]      rsp_inflight_coalesced
);

   localparam int unsigned AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int unsigned KW = rct_pkg::KEY_W;

   // Entry memory.
   rct_pkg::entry_type mem [NUM_KEYS];
   rct_pkg::entry_type rd_data_ff;
   logic               mem_wr_en;
   logic [AW-1:0]      mem_wr_addr;
   rct_pkg::entry_type mem_wr_data;

   // Controller.
   rct_pkg::state_type state_ff, state_in;
   logic [AW-1:0]      clear_idx_ff, clear_idx_in;
   logic               accept;
   logic               upd_fire;

   // Captured item.
   logic          item_kind_ff;
   logic [1:0]    item_pkind_ff;
   logic [1:0]    item_fkind_ff;
   logic          item_marked_ff;
   logic [31:0]   item_now_ff;
   logic [AW-1:0] item_idx_ff;

   logic [KW-1:0] key_rem;
   logic [AW-1:0] key_idx;

   logic [15:0]   window_cycles_ff;

   // Statistics counters; they also drive the result's counter fields.
   logic [31:0] heads_cnt_ff,    heads_cnt_in;
   logic [31:0] gdup_cnt_ff,     gdup_cnt_in;
   logic [31:0] wdup_cnt_ff,     wdup_cnt_in;
   logic [31:0] idup_cnt_ff,     idup_cnt_in;

   // Result register.
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_mark_ff, rsp_gdup_ff, rsp_wdup_ff, rsp_idup_ff;

   // Update results.
   rct_pkg::entry_type upd_entry;
   logic upd_mark, upd_gdup, upd_wdup, upd_idup, upd_head;
   logic is_head, is_tail;
   logic [32:0] window_end;
   logic        in_window;

   // The key is reduced modulo NUM_KEYS by conditional subtraction of the
   // shifted table size; steps whose shifted size exceeds the key range
   // fall away at elaboration.
   always_comb begin
      key_rem = req_feature_key;
      for (int k = KW - 1; k >= 0; k--) begin
         if ((64'(NUM_KEYS) << k) < (64'd1 << KW)) begin
            if (64'(key_rem) >= (64'(NUM_KEYS) << k)) begin
               key_rem = key_rem - KW'(64'(NUM_KEYS) << k);
            end
         end
      end
      key_idx = AW'(key_rem);
   end

   assign accept = req_valid && req_ready;

   // Next state and controls.
   always_comb begin
      state_in     = state_ff;
      clear_idx_in = clear_idx_ff;
      req_ready    = 1'b0;
      upd_fire     = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = item_idx_ff;
      mem_wr_data  = upd_entry;
      case (state_ff)
         rct_pkg::ST_CLEAR: begin
            mem_wr_en    = 1'b1;
            mem_wr_addr  = clear_idx_ff;
            mem_wr_data  = '0;
            clear_idx_in = clear_idx_ff + AW'(1);
            if (clear_idx_ff == AW'(NUM_KEYS - 1)) begin
               state_in = rct_pkg::ST_IDLE;
            end
         end
         rct_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = rct_pkg::ST_LOOKUP;
            end
         end
         rct_pkg::ST_LOOKUP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               upd_fire  = 1'b1;
               mem_wr_en = 1'b1;
               state_in  = rct_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rct_pkg::ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rct_pkg::ST_CLEAR;
         clear_idx_ff <= '0;
      end else begin
         state_ff     <= state_in;
         clear_idx_ff <= clear_idx_in;
      end
   end

   // Memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (accept) begin
         rd_data_ff <= mem[key_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_kind_ff   <= req_kind;
         item_pkind_ff  <= req_packet_kind;
         item_fkind_ff  <= req_flit_kind;
         item_marked_ff <= req_already_marked;
         item_now_ff    <= req_now_cycle;
         item_idx_ff    <= key_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_cycles_ff <= rct_pkg::WINDOW_RESET;
      end else if (csr_wr_en) begin
         window_cycles_ff <= csr_wr_data;
      end
   end

   // Read-modify-write of the entry.
   always_comb begin
      is_head    = (item_fkind_ff == rct_pkg::FLIT_HEAD) ||
                   (item_fkind_ff == rct_pkg::FLIT_HEAD_TAIL);
      is_tail    = (item_fkind_ff == rct_pkg::FLIT_TAIL) ||
                   (item_fkind_ff == rct_pkg::FLIT_HEAD_TAIL);
      window_end = {1'b0, rd_data_ff.window_start} + {17'd0, window_cycles_ff};
      in_window  = {1'b0, item_now_ff} <= window_end;
      upd_entry  = rd_data_ff;
      upd_mark   = 1'b0;
      upd_gdup   = 1'b0;
      upd_wdup   = 1'b0;
      upd_idup   = 1'b0;
      upd_head   = 1'b0;

      if (item_kind_ff == rct_pkg::KIND_QUERY) begin
         upd_mark = (item_pkind_ff == rct_pkg::PKT_REQUEST) && is_head &&
                    ((rd_data_ff.global_seen > 16'd1) || (rd_data_ff.window_seen > 16'd1));
      end else if (item_pkind_ff == rct_pkg::PKT_RESPONSE) begin
         if (is_tail) begin
            if (rd_data_ff.old_pending != '0) begin
               upd_entry.old_pending = rd_data_ff.old_pending - 16'd1;
            end else if (rd_data_ff.batch_outstanding != '0) begin
               // The first response ends the batch; the rest become pending.
               upd_entry.old_pending       = rd_data_ff.batch_outstanding - 16'd1;
               upd_entry.batch_outstanding = '0;
            end
         end
      end else if ((item_pkind_ff == rct_pkg::PKT_REQUEST) && is_head && !item_marked_ff) begin
         upd_head = 1'b1;

         if (rd_data_ff.global_seen == '0) begin
            upd_entry.global_seen = 16'd1;
         end else begin
            upd_entry.global_seen = rct_pkg::sat_inc(rd_data_ff.global_seen);
            upd_gdup              = 1'b1;
         end

         if ((rd_data_ff.window_seen != '0) && in_window) begin
            upd_entry.window_seen = rct_pkg::sat_inc(rd_data_ff.window_seen);
            upd_wdup              = 1'b1;
         end else begin
            // A fresh key or an expired window opens a new window.
            upd_entry.window_start = item_now_ff;
            upd_entry.window_seen  = 16'd1;
         end

         if (rd_data_ff.batch_outstanding != '0) begin
            upd_entry.batch_outstanding = rct_pkg::sat_inc(rd_data_ff.batch_outstanding);
            upd_idup                    = 1'b1;
         end else begin
            upd_entry.batch_outstanding = 16'd1;
         end
      end
   end

   always_comb begin
      heads_cnt_in = heads_cnt_ff;
      gdup_cnt_in  = gdup_cnt_ff;
      wdup_cnt_in  = wdup_cnt_ff;
      idup_cnt_in  = idup_cnt_ff;
      if (upd_fire) begin
         heads_cnt_in = heads_cnt_ff + 32'(upd_head);
         gdup_cnt_in  = gdup_cnt_ff + 32'(upd_gdup);
         wdup_cnt_in  = wdup_cnt_ff + 32'(upd_wdup);
         idup_cnt_in  = idup_cnt_ff + 32'(upd_idup);
      end
      if (upd_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heads_cnt_ff <= '0;
         gdup_cnt_ff  <= '0;
         wdup_cnt_ff  <= '0;
         idup_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         heads_cnt_ff <= heads_cnt_in;
         gdup_cnt_ff  <= gdup_cnt_in;
         wdup_cnt_ff  <= wdup_cnt_in;
         idup_cnt_ff  <= idup_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_fire) begin
         rsp_mark_ff <= upd_mark;
         rsp_gdup_ff <= upd_gdup;
         rsp_wdup_ff <= upd_wdup;
         rsp_idup_ff <= upd_idup;
      end
   end

   // The counters only move when a new result is loaded, so they stay
   // aligned with the result register.
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_coalesce_mark      = rsp_mark_ff;
   assign rsp_global_dup         = rsp_gdup_ff;
   assign rsp_window_dup         = rsp_wdup_ff;
   assign rsp_inflight_dup       = rsp_idup_ff;
   assign rsp_heads_total        = heads_cnt_ff;
   assign rsp_global_coalesced   = gdup_cnt_ff;
   assign rsp_window_coalesced   = wdup_cnt_ff;
   assign rsp_inflight_coalesced = idup_cnt_ff;

   // An accepted item always moves on to the entry lookup.
   `RCT_ASSERT_NEXT(a_accept_to_lookup, clock, reset, accept,
      (state_ff == rct_pkg::ST_LOOKUP) && !req_ready, "accepted item did not enter lookup")

   // A lookup that finds the result register free produces a result.
   `RCT_ASSERT_NEXT(a_lookup_gives_result, clock, reset, upd_fire, rsp_valid,
      "lookup completed without a result")

   // A query result never carries arrival duplicate flags.
   `RCT_ASSERT_NOW(a_mark_excludes_dup, clock, reset, rsp_valid && rsp_coalesce_mark,
      !rsp_global_dup && !rsp_window_dup && !rsp_inflight_dup,
      "coalesce mark together with arrival flags")

endmodule

`default_nettype wire
